### src/action_rate_and_region_guard_unit_defines.svh
// Assertion macros shared by the guard unit RTL.
// Sampled on clk and disabled while arst_n is low; needs no other file.
`ifndef ACTION_RATE_AND_REGION_GUARD_UNIT_DEFINES_SVH
`define ACTION_RATE_AND_REGION_GUARD_UNIT_DEFINES_SVH

// expression must hold at every clock edge
`define AGR_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AGR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/agr_pkg.sv
// Shared types and codes for the action rate and region guard.
// No dependencies; used by every module of the block.
package agr_pkg;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_CHECK  = 2'd1;
	localparam logic [1:0] ACT_RECORD = 2'd2;
	localparam logic [1:0] ACT_ADD    = 2'd3;

	localparam logic [1:0] KIND_CLICK  = 2'd0;
	localparam logic [1:0] KIND_SCROLL = 2'd1;

	localparam logic [1:0] REG_SAFETY_ENABLE = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;
	localparam logic [1:0] REG_MAX_ACTIONS   = 2'd3;

	localparam logic        RST_SAFETY_ENABLE = 1'b1;
	localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd1920;
	localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd1080;
	localparam logic [6:0]  RST_MAX_ACTIONS   = 7'd10;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         action_kind;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [14:0]        region_width;
		logic [14:0]        region_height;
	} in_t;

	typedef struct packed {
		logic       safe;
		logic [6:0] recent_count;
	} out_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        w;
		logic [14:0]        h;
	} region_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} region_status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ring_status_t;

endpackage

### src/action_rate_and_region_guard_unit.sv
// Top level of the action rate and region guard: config registers, tick
// counter, check sequencer and result register. Depends on agr_pkg,
// agr_region_scan, agr_stamp_ring and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | input     | in_valid / in_ready  | in_data   (agr_pkg::in_t)
//  out     | output    | out_valid / out_ready| out_data  (agr_pkg::out_t)
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Sequence: tick, record and add beats complete at the accepting edge; in_ready
//   stays high. A click or scroll check scans every stored region (one region
//   RAM read per cycle), then walks the ring popping each expired stamp (one ring
//   RAM read per cycle, next slot fetched ahead); other kinds skip the scan.
//   Early outs (safety off, off screen, region hit skips the walk) go straight
//   to the result hold. in_ready returns with out_valid.
// Reset: arst_n clears counters and state and loads config defaults; both RAMs
//   stay undefined and are tracked by fill counts, so there is no clearing pass.
// Stalls: a finished check waits in the sequencer until the output register
//   is free; in_ready stays low until then. A result waiting in the output
//   register does not block non-check beats.
`include "action_rate_and_region_guard_unit_defines.svh"

module action_rate_and_region_guard_unit #(
	parameter int MAX_RECENT       = 64,
	parameter int MAX_REGIONS      = 16,
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  agr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output agr_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [14:0]   cfg_wdata
);

	localparam int RCW = $clog2(MAX_RECENT + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_REGION = 5'b00100,
		S_RATE   = 5'b01000,
		S_HOLD   = 5'b10000
	} state_t;

	state_t state_q;

	// config registers
	logic        safety_q;
	logic [14:0] scr_w_q;
	logic [14:0] scr_h_q;
	logic [6:0]  limit_q;

	logic [31:0]   now_q;
	agr_pkg::in_t  item_q;
	logic          safe_q;
	agr_pkg::out_t out_q;
	logic          out_valid_q;

	logic                    accept;
	logic                    spatial;
	logic                    screen_ok;
	logic                    region_start;
	logic                    ring_start;
	logic                    out_free;
	logic [RCW-1:0]          ring_cnt;
	logic [31:0]             cnt_ext;
	agr_pkg::region_t        add_region;
	agr_pkg::region_status_t rg_st;
	agr_pkg::ring_status_t   rn_st;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// click and scroll get the spatial test; other kinds skip it
	assign spatial   = (item_q.action_kind == agr_pkg::KIND_CLICK) ||
		(item_q.action_kind == agr_pkg::KIND_SCROLL);
	// inclusive screen box at the origin: sign bit must be clear
	assign screen_ok = !item_q.point_x[15] && !item_q.point_y[15] &&
		(item_q.point_x[14:0] <= scr_w_q) && (item_q.point_y[14:0] <= scr_h_q);

	assign region_start = (state_q == S_CHECK) && safety_q && spatial && screen_ok;
	assign ring_start   = ((state_q == S_CHECK) && safety_q && !spatial) ||
		((state_q == S_REGION) && rg_st.done && !rg_st.hit);

	assign add_region.left = in_data.point_x;
	assign add_region.top  = in_data.point_y;
	assign add_region.w    = in_data.region_width;
	assign add_region.h    = in_data.region_height;

	agr_region_scan #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_region (
		.clk       (clk),
		.arst_n    (arst_n),
		.add_en    (accept && (in_data.action == agr_pkg::ACT_ADD)),
		.add_region(add_region),
		.start     (region_start),
		.x         (item_q.point_x),
		.y         (item_q.point_y),
		.status    (rg_st)
	);

	agr_stamp_ring #(
		.MAX_RECENT      (MAX_RECENT),
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept && (in_data.action == agr_pkg::ACT_RECORD)),
		.start (ring_start),
		.now   (now_q),
		.status(rn_st),
		.count (ring_cnt)
	);

	// result count is the ring fill masked to seven bits
	assign cnt_ext = 32'(ring_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safety_q <= agr_pkg::RST_SAFETY_ENABLE;
			scr_w_q  <= agr_pkg::RST_SCREEN_WIDTH;
			scr_h_q  <= agr_pkg::RST_SCREEN_HEIGHT;
			limit_q  <= agr_pkg::RST_MAX_ACTIONS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				agr_pkg::REG_SAFETY_ENABLE: safety_q <= cfg_wdata[0];
				agr_pkg::REG_SCREEN_WIDTH:  scr_w_q  <= cfg_wdata;
				agr_pkg::REG_SCREEN_HEIGHT: scr_h_q  <= cfg_wdata;
				agr_pkg::REG_MAX_ACTIONS:   limit_q  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			safe_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// in S_HOLD the load below decides out_valid_q
			if (out_valid_q && out_ready && (state_q != S_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.action == agr_pkg::ACT_TICK) begin
							now_q <= now_q + 32'd1;
						end
						if (in_data.action == agr_pkg::ACT_CHECK) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (!safety_q) begin
						safe_q  <= 1'b1;
						state_q <= S_HOLD;
					end else if (spatial && !screen_ok) begin
						safe_q  <= 1'b0;
						state_q <= S_HOLD;
					end else if (spatial) begin
						state_q <= S_REGION;
					end else begin
						state_q <= S_RATE;
					end
				end
				S_REGION: begin
					if (rg_st.done) begin
						if (rg_st.hit) begin
							safe_q  <= 1'b0;
							state_q <= S_HOLD;
						end else begin
							state_q <= S_RATE;
						end
					end
				end
				S_RATE: begin
					// count is final when done is seen
					if (rn_st.done) begin
						safe_q  <= (32'(ring_cnt) < 32'(limit_q));
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						out_q.safe         <= safe_q;
						out_q.recent_count <= cnt_ext[6:0];
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`AGR_ASSERT_ALWAYS(a_units_exclusive, !(rg_st.busy && rn_st.busy), "scan and prune overlap")
	`AGR_ASSERT_IMPL(a_idle_units, in_ready, !rg_st.busy && !rn_st.busy, "unit busy while idle")
	`AGR_ASSERT_IMPL(a_scan_done_state, rg_st.done, state_q == S_REGION, "stray scan done")
	`AGR_ASSERT_IMPL(a_ring_done_state, rn_st.done, state_q == S_RATE, "stray prune done")

endmodule

### src/agr_region_scan.sv
// Forbidden region table in a synchronous RAM plus a sequential hit scan.
// Depends on agr_pkg.
module agr_region_scan #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   add_en,
	input  agr_pkg::region_t       add_region,
	input  logic                   start,
	input  logic signed [15:0]     x,
	input  logic signed [15:0]     y,
	output agr_pkg::region_status_t status
);

	localparam int RA = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);

	agr_pkg::region_t mem [MAX_REGIONS];
	agr_pkg::region_t region_s1;

	logic [CW-1:0] count_q;
	logic [RA-1:0] idx_q;
	logic [RA-1:0] rd_addr;
	logic          issue_q;
	logic          vld_s1;
	logic          last_s1;
	logic          done_q;
	logic          hit_q;
	logic          match;
	logic signed [16:0] right;
	logic signed [16:0] bottom;
	logic signed [16:0] left_e;
	logic signed [16:0] top_e;
	logic signed [16:0] x_e;
	logic signed [16:0] y_e;

	assign rd_addr = start ? '0 : idx_q;

	always_ff @(posedge clk) begin
		if (add_en && (count_q < CW'(MAX_REGIONS))) begin
			mem[count_q[RA-1:0]] <= add_region;
		end
		region_s1 <= mem[rd_addr];
	end

	// half-open containment, 17-bit so the edge sum cannot wrap
	always_comb begin
		x_e    = {x[15], x};
		y_e    = {y[15], y};
		left_e = {region_s1.left[15], region_s1.left};
		top_e  = {region_s1.top[15], region_s1.top};
		right  = left_e + $signed({2'b00, region_s1.w});
		bottom = top_e + $signed({2'b00, region_s1.h});
		match  = (x_e >= left_e) && (x_e < right) && (y_e >= top_e) && (y_e < bottom);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			if (add_en && (count_q < CW'(MAX_REGIONS))) begin
				count_q <= count_q + 1'b1;
			end
			if (start) begin
				hit_q <= 1'b0;
				if (count_q == '0) begin
					done_q <= 1'b1;
				end else begin
					vld_s1  <= 1'b1;
					last_s1 <= (count_q == CW'(1));
					issue_q <= (count_q != CW'(1));
					idx_q   <= RA'(1);
				end
			end else if (issue_q) begin
				vld_s1  <= 1'b1;
				last_s1 <= (CW'(idx_q) == count_q - 1'b1);
				issue_q <= (CW'(idx_q) != count_q - 1'b1);
				idx_q   <= idx_q + 1'b1;
			end
			if (vld_s1) begin
				hit_q <= hit_q | match;
				if (last_s1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = issue_q | vld_s1;
	assign status.done = done_q;
	assign status.hit  = hit_q;

endmodule

### src/agr_stamp_ring.sv
// Timestamp ring in a synchronous RAM with push and an expiry prune walk.
// Depends on agr_pkg.
module agr_stamp_ring #(
	parameter int MAX_RECENT       = 64,
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 start,
	input  logic [31:0]                          now,
	output agr_pkg::ring_status_t                status,
	output logic [$clog2(MAX_RECENT + 1)-1:0]    count
);

	localparam int RA = (MAX_RECENT > 1) ? $clog2(MAX_RECENT) : 1;
	localparam int CW = $clog2(MAX_RECENT + 1);
	localparam logic [31:0] WINDOW = 32'(2 * TICKS_PER_SECOND);

	logic [31:0]   mem [MAX_RECENT];
	logic [31:0]   stamp_s1;
	logic [RA-1:0] head_q;
	logic [RA-1:0] head_inc;
	logic [RA-1:0] rd_addr;
	logic [RA-1:0] wr_addr;
	logic [CW-1:0] cnt_q;
	logic [CW:0]   wsum;
	logic [CW:0]   wwrap;
	logic [31:0]   age;
	logic          expired;
	logic          busy_q;
	logic          done_q;
	logic          can_push;

	assign can_push = push && (cnt_q < CW'(MAX_RECENT));
	assign head_inc = (head_q == RA'(MAX_RECENT - 1)) ? '0 : head_q + 1'b1;
	assign wsum     = {1'b0, CW'(head_q)} + {1'b0, cnt_q};
	assign wwrap    = wsum - (CW + 1)'(MAX_RECENT);
	assign wr_addr  = (wsum >= (CW + 1)'(MAX_RECENT)) ? wwrap[RA-1:0] : wsum[RA-1:0];
	// while walking, fetch the next slot ahead so each pop does not wait on a RAM read
	assign rd_addr  = start ? head_q : head_inc;
	assign age      = now - stamp_s1;
	assign expired  = age >= WINDOW;

	always_ff @(posedge clk) begin
		if (can_push) begin
			mem[wr_addr] <= now;
		end
		stamp_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (can_push) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (start) begin
				if (cnt_q == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (expired) begin
					head_q <= head_inc;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign count       = cnt_q;

endmodule
